// ===== hdl/sds_pkg.sv =====
// Shared types, constants and control structs of the SCAN disk scheduler.
`default_nettype none
package sds_pkg;

  localparam int MAX_BATCH  = 32;
  localparam int TRACK_BITS = 16;
  localparam int CNT_W      = $clog2(MAX_BATCH + 1);
  localparam int SEEK_W     = 22;
  localparam int SUM_W      = ((SEEK_W > TRACK_BITS) ? SEEK_W : TRACK_BITS) + 1;
  localparam int DT_W       = 17;
  localparam int WIDE_W     = 33;
  localparam int CFG_W      = 17;

  typedef logic [TRACK_BITS-1:0] track_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [SEEK_W-1:0]     seek_t;
  typedef logic [1:0]            cfg_index_t;

  localparam seek_t  SEEK_MAX  = '1;
  localparam track_t TRACK_MAX = '1;
  localparam logic [DT_W-1:0] DISK_TRACKS_RESET = DT_W'(65536);

  localparam cfg_index_t CFG_HEAD   = 2'd0;
  localparam cfg_index_t CFG_TRACKS = 2'd1;
  localparam cfg_index_t CFG_SWEEP  = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP,
    OP_PUSH
  } chain_op_t;

  typedef struct packed {
    chain_op_t op;
    track_t    din;
  } chain_ctrl_t;

  typedef struct packed {
    count_t count;
    logic   empty;
    logic   full;
    track_t front;
  } chain_stat_t;

  typedef struct packed {
    logic   occ;
    logic   gt;
    track_t value;
  } cell_link_t;

endpackage
`default_nettype wire

// ===== hdl/sds_cell.sv =====
// One cell of a track chain: holds one track, shifts or inserts with its neighbors.
`default_nettype none
module sds_cell (
  input  wire logic                clk,
  input  wire sds_pkg::chain_ctrl_t ctrl,
  input  wire logic                occ,
  input  wire sds_pkg::cell_link_t left,
  input  wire sds_pkg::track_t     right_value,
  output sds_pkg::cell_link_t      link
);

  sds_pkg::track_t value;
  sds_pkg::track_t value_next;
  logic            gt;

  assign gt   = occ && (value > ctrl.din);
  assign link = '{occ: occ, gt: gt, value: value};

  always_comb begin
    value_next = value;
    unique case (ctrl.op)
      sds_pkg::OP_HOLD: value_next = value;
      sds_pkg::OP_INSERT: begin
        // first larger cell or first free cell takes the new track, the rest shift up
        if (gt || (!occ && left.occ)) begin
          value_next = left.gt ? left.value : ctrl.din;
        end
      end
      sds_pkg::OP_POP:  value_next = right_value;
      sds_pkg::OP_PUSH: value_next = left.value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule
`default_nettype wire

// ===== hdl/sds_chain.sv =====
// Row of track cells with an occupancy count: sorted insert, pop at the front, push.
`default_nettype none
module sds_chain (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire sds_pkg::chain_ctrl_t ctrl,
  output sds_pkg::chain_stat_t      stat
);

  sds_pkg::count_t                  count;
  sds_pkg::count_t                  count_next;
  logic [sds_pkg::MAX_BATCH-1:0]    occ;
  sds_pkg::cell_link_t              links [sds_pkg::MAX_BATCH];
  sds_pkg::cell_link_t              lefts [sds_pkg::MAX_BATCH];
  sds_pkg::track_t                  rights [sds_pkg::MAX_BATCH];
  logic                             full;
  logic                             empty;

  assign full  = (count == sds_pkg::count_t'(sds_pkg::MAX_BATCH));
  assign empty = (count == '0);
  assign stat  = '{count: count, empty: empty, full: full, front: links[0].value};

  for (genvar i = 0; i < sds_pkg::MAX_BATCH; i++) begin : g_cell
    assign occ[i] = (sds_pkg::count_t'(i) < count);
    if (i == 0) begin : g_first
      assign lefts[i] = '{occ: 1'b1, gt: 1'b0, value: ctrl.din};
    end else begin : g_mid
      assign lefts[i] = links[i-1];
    end
    if (i == sds_pkg::MAX_BATCH - 1) begin : g_last
      assign rights[i] = ctrl.din;
    end else begin : g_inner
      assign rights[i] = links[i+1].value;
    end
    sds_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ[i]),
      .left        (lefts[i]),
      .right_value (rights[i]),
      .link        (links[i])
    );
  end

  always_comb begin
    count_next = count;
    unique case (ctrl.op)
      sds_pkg::OP_HOLD: count_next = count;
      sds_pkg::OP_INSERT, sds_pkg::OP_PUSH: begin
        if (!full) begin
          count_next = count + sds_pkg::count_t'(1);
        end
      end
      sds_pkg::OP_POP: begin
        if (!empty) begin
          count_next = count - sds_pkg::count_t'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/scan_disk_scheduler.sv =====
// Top level of the SCAN disk scheduler: request chain, split stack and visit sequencer.
//
//   channel  | handshake               | fields
//   ---------+-------------------------+--------------------------------------------
//   in       | in_valid / in_stall     | request_track, last_request
//   out      | out_valid / out_stall   | visit_track, edge_visit, seek_so_far,
//            |                         | requests_dropped, last_visit
//   cfg      | cfg_we                  | cfg_index, cfg_data
//
// One request per cycle while in_stall is low; the sorted insert into the cell row
// settles in that cycle. After the last request, tracks move to the stack (below the
// head sweeping up, at or below it sweeping down), then the first sweep is visited, then
// the disk end unless the head is already there, then the second sweep; output stalls
// hold this. in_stall stays high until load resumes, after the final visit is
// registered. out_stall holds the output register. Synchronous reset, no clearing pass.
`default_nettype none
module scan_disk_scheduler (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] request_track,
  input  wire logic        last_request,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      visit_track,
  output logic             edge_visit,
  output logic [21:0]      seek_so_far,
  output logic             requests_dropped,
  output logic             last_visit,
  input  wire logic        cfg_we,
  input  wire sds_pkg::cfg_index_t cfg_index,
  input  wire logic [sds_pkg::CFG_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_SPLIT,
    S_EMIT_A,
    S_EDGE,
    S_EMIT_B
  } state_t;

  state_t                      state;
  state_t                      state_next;
  logic [15:0]                 head_position;
  logic [sds_pkg::DT_W-1:0]    disk_tracks;
  logic                        sweep_up;
  logic                        overflow;
  sds_pkg::track_t             cur;
  sds_pkg::seek_t              seek;

  sds_pkg::chain_ctrl_t        main_ctrl;
  sds_pkg::chain_ctrl_t        stack_ctrl;
  sds_pkg::chain_stat_t        main_stat;
  sds_pkg::chain_stat_t        stack_stat;
  sds_pkg::chain_stat_t        a_stat;
  sds_pkg::chain_stat_t        b_stat;

  sds_pkg::track_t             head;
  sds_pkg::track_t             top;
  sds_pkg::track_t             target;
  logic [sds_pkg::WIDE_W-1:0]  tracks_m1;
  logic                        slot_free;
  logic                        to_stack;

  logic                        emit;
  sds_pkg::track_t             emit_track;
  logic                        emit_edge;
  logic                        emit_last;
  sds_pkg::track_t             move_dist;
  logic [sds_pkg::SUM_W-1:0]   seek_sum;
  sds_pkg::seek_t              seek_next;

  sds_chain u_main (
    .clk  (clk),
    .rst  (rst),
    .ctrl (main_ctrl),
    .stat (main_stat)
  );

  sds_chain u_stack (
    .clk  (clk),
    .rst  (rst),
    .ctrl (stack_ctrl),
    .stat (stack_stat)
  );

  assign head      = sds_pkg::track_t'(head_position);
  assign tracks_m1 = sds_pkg::WIDE_W'(disk_tracks) - sds_pkg::WIDE_W'(1);

  always_comb begin
    if (disk_tracks == '0) begin
      top = '0;
    end else if (tracks_m1 > sds_pkg::WIDE_W'(sds_pkg::TRACK_MAX)) begin
      top = sds_pkg::TRACK_MAX;
    end else begin
      top = sds_pkg::track_t'(tracks_m1);
    end
  end

  assign target    = sweep_up ? top : '0;
  assign a_stat    = sweep_up ? main_stat : stack_stat;
  assign b_stat    = sweep_up ? stack_stat : main_stat;
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_LOAD);
  assign to_stack  = !main_stat.empty &&
                     (sweep_up ? (main_stat.front < head) : (main_stat.front <= head));

  assign move_dist = (emit_track > cur) ? (emit_track - cur) : (cur - emit_track);
  assign seek_sum  = sds_pkg::SUM_W'(seek) + sds_pkg::SUM_W'(move_dist);
  assign seek_next = (seek_sum > sds_pkg::SUM_W'(sds_pkg::SEEK_MAX)) ?
                     sds_pkg::SEEK_MAX : sds_pkg::seek_t'(seek_sum);

  always_comb begin
    state_next = state;
    main_ctrl  = '{op: sds_pkg::OP_HOLD, din: sds_pkg::track_t'(request_track)};
    stack_ctrl = '{op: sds_pkg::OP_HOLD, din: main_stat.front};
    emit       = 1'b0;
    emit_track = a_stat.front;
    emit_edge  = 1'b0;
    emit_last  = 1'b0;
    unique case (state)
      S_LOAD: begin
        if (in_valid) begin
          if (!main_stat.full) begin
            main_ctrl.op = sds_pkg::OP_INSERT;
          end
          if (last_request) begin
            state_next = S_SPLIT;
          end
        end
      end
      S_SPLIT: begin
        if (to_stack) begin
          main_ctrl.op  = sds_pkg::OP_POP;
          stack_ctrl.op = sds_pkg::OP_PUSH;
        end else begin
          state_next = S_EMIT_A;
        end
      end
      S_EMIT_A: begin
        if (a_stat.empty) begin
          state_next = S_EDGE;
        end else if (slot_free) begin
          emit       = 1'b1;
          emit_track = a_stat.front;
          emit_last  = (a_stat.count == sds_pkg::count_t'(1)) &&
                       (a_stat.front == target) && b_stat.empty;
          if (sweep_up) begin
            main_ctrl.op = sds_pkg::OP_POP;
          end else begin
            stack_ctrl.op = sds_pkg::OP_POP;
          end
        end
      end
      S_EDGE: begin
        if (cur == target) begin
          state_next = S_EMIT_B;
        end else if (slot_free) begin
          emit       = 1'b1;
          emit_track = target;
          emit_edge  = 1'b1;
          emit_last  = b_stat.empty;
          state_next = S_EMIT_B;
        end
      end
      S_EMIT_B: begin
        if (b_stat.empty) begin
          state_next = S_LOAD;
        end else if (slot_free) begin
          emit       = 1'b1;
          emit_track = b_stat.front;
          emit_last  = (b_stat.count == sds_pkg::count_t'(1));
          if (sweep_up) begin
            stack_ctrl.op = sds_pkg::OP_POP;
          end else begin
            main_ctrl.op = sds_pkg::OP_POP;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      head_position <= '0;
      disk_tracks   <= sds_pkg::DISK_TRACKS_RESET;
      sweep_up      <= 1'b1;
      overflow      <= 1'b0;
      cur           <= '0;
      seek          <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          sds_pkg::CFG_HEAD:   head_position <= cfg_data[15:0];
          sds_pkg::CFG_TRACKS: disk_tracks   <= cfg_data[sds_pkg::DT_W-1:0];
          sds_pkg::CFG_SWEEP:  sweep_up      <= cfg_data[0];
          default: ;
        endcase
      end
      if ((state == S_LOAD) && in_valid) begin
        if (main_stat.full) begin
          overflow <= 1'b1;
        end
        if (last_request) begin
          cur  <= head;
          seek <= '0;
        end
      end
      if ((state == S_EMIT_B) && b_stat.empty) begin
        overflow <= 1'b0;
      end
      if (emit) begin
        cur              <= emit_track;
        seek             <= seek_next;
        out_valid        <= 1'b1;
        visit_track      <= 16'(emit_track);
        edge_visit       <= emit_edge;
        seek_so_far      <= seek_next;
        requests_dropped <= overflow;
        last_visit       <= emit_last;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for scan_disk_scheduler: random batches against a SCAN order predictor.
`timescale 1ns / 1ps
module tb;
  import sds_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 2 * MAX_BATCH + 10;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [15:0]          request_track = '0;
  logic                 last_request = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [15:0]          visit_track;
  logic                 edge_visit;
  logic [21:0]          seek_so_far;
  logic                 requests_dropped;
  logic                 last_visit;
  logic                 cfg_we = 1'b0;
  cfg_index_t           cfg_index = CFG_HEAD;
  logic [CFG_W-1:0]     cfg_data = '0;

  typedef struct {
    track_t track;
    bit     edge_flag;
    seek_t  seek;
    bit     dropped;
    bit     final_flag;
  } visit_t;

  class scan_schedule_sb;
    int               head_pos;
    int               num_tracks;
    bit               up_first;
    track_t           batch_tracks[$];
    bit               batch_overflow;
    visit_t           due_visits[$];
    int               errors;
    int               head_now;
    int               seek_sum;

    function new();
      head_pos = 0;
      num_tracks = 65536;
      up_first = 1'b1;
      batch_overflow = 1'b0;
      errors = 0;
      head_now = 0;
      seek_sum = 0;
    endfunction

    function void set_config(int head, int tracks, bit up);
      head_pos = head & 16'hFFFF;
      num_tracks = tracks & 17'h1FFFF;
      up_first = up;
    endfunction

    function void add_visit(int trk, bit is_edge);
      visit_t v;
      seek_sum += (trk > head_now) ? trk - head_now : head_now - trk;
      if (seek_sum > int'(SEEK_MAX))
        seek_sum = int'(SEEK_MAX);
      head_now = trk;
      v.track = track_t'(trk);
      v.edge_flag = is_edge;
      v.seek = seek_t'(seek_sum);
      v.dropped = batch_overflow;
      v.final_flag = 1'b0;
      due_visits.push_back(v);
    endfunction

    function void note_request(track_t trk, bit last);
      int pos;
      int top_trk;
      if (batch_tracks.size() >= MAX_BATCH) begin
        batch_overflow = 1'b1;
      end else begin
        pos = 0;
        while (pos < batch_tracks.size() && batch_tracks[pos] <= trk)
          pos++;
        batch_tracks.insert(pos, trk);
      end
      if (!last)
        return;
      top_trk = (num_tracks == 0) ? 0 : num_tracks - 1;
      if (top_trk > 65535)
        top_trk = 65535;
      head_now = head_pos;
      seek_sum = 0;
      if (up_first) begin
        foreach (batch_tracks[i])
          if (int'(batch_tracks[i]) >= head_pos)
            add_visit(batch_tracks[i], 1'b0);
        if (head_now != top_trk)
          add_visit(top_trk, 1'b1);
        for (int i = batch_tracks.size() - 1; i >= 0; i--)
          if (int'(batch_tracks[i]) < head_pos)
            add_visit(batch_tracks[i], 1'b0);
      end else begin
        for (int i = batch_tracks.size() - 1; i >= 0; i--)
          if (int'(batch_tracks[i]) <= head_pos)
            add_visit(batch_tracks[i], 1'b0);
        if (head_now != 0)
          add_visit(0, 1'b1);
        foreach (batch_tracks[i])
          if (int'(batch_tracks[i]) > head_pos)
            add_visit(batch_tracks[i], 1'b0);
      end
      due_visits[due_visits.size() - 1].final_flag = 1'b1;
      batch_tracks.delete();
      batch_overflow = 1'b0;
    endfunction

    function void check_visit(logic [15:0] trk, logic is_edge, logic [21:0] seek,
                              logic dropped, logic fin);
      visit_t v;
      if (due_visits.size() == 0) begin
        $error("unexpected visit: track %0d", trk);
        errors++;
        return;
      end
      v = due_visits.pop_front();
      if (trk !== v.track) begin
        $error("visit_track: expected %0d, got %0d", v.track, trk);
        errors++;
      end
      if (is_edge !== v.edge_flag) begin
        $error("edge_visit: expected %0d, got %0d", v.edge_flag, is_edge);
        errors++;
      end
      if (seek !== v.seek) begin
        $error("seek_so_far: expected %0d, got %0d", v.seek, seek);
        errors++;
      end
      if (dropped !== v.dropped) begin
        $error("requests_dropped: expected %0d, got %0d", v.dropped, dropped);
        errors++;
      end
      if (fin !== v.final_flag) begin
        $error("last_visit: expected %0d, got %0d", v.final_flag, fin);
        errors++;
      end
    endfunction

    function bit pending();
      return due_visits.size() != 0;
    endfunction
  endclass

  scan_schedule_sb sb;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int stall_left = 0;
  int cycles = 0;
  int items_sent = 0;
  int cur_head = 0;

  scan_disk_scheduler dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .request_track(request_track), .last_request(last_request),
    .out_valid(out_valid), .out_stall(out_stall),
    .visit_track(visit_track), .edge_visit(edge_visit), .seek_so_far(seek_so_far),
    .requests_dropped(requests_dropped), .last_visit(last_visit),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("scan_disk_scheduler test failed");
      $finish;
    end
  end

  // visit sink with random backpressure
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        sb.check_visit(visit_track, edge_visit, seek_so_far, requests_dropped, last_visit);
        stall_left = rx_quiet ? 0 : $urandom_range(0, 15);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_request(input track_t trk, input bit last);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    request_track <= trk;
    last_request <= last;
    do @(posedge clk); while (in_stall);
    sb.note_request(trk, last);
    items_sent++;
  endtask

  // stop sending and let every pending visit come out
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending()) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int head, input int tracks, input bit up);
    cfg_we <= 1'b1;
    cfg_index <= CFG_HEAD;
    cfg_data <= CFG_W'(head);
    @(posedge clk);
    cfg_index <= CFG_TRACKS;
    cfg_data <= CFG_W'(tracks);
    @(posedge clk);
    cfg_index <= CFG_SWEEP;
    cfg_data <= CFG_W'(up);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(head, tracks, up);
    cur_head = head;
  endtask

  function automatic track_t pick_track();
    int v;
    case ($urandom_range(0, 5))
      0: v = cur_head;
      1: begin
        v = cur_head + $urandom_range(0, 16) - 8;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
      end
      2: v = $urandom_range(0, 1) ? 65535 : 0;
      3: v = $urandom_range(0, 63);
      default: v = $urandom_range(0, 65535);
    endcase
    return track_t'(v);
  endfunction

  task automatic run_batch(input int size);
    for (int i = 0; i < size; i++)
      send_request(pick_track(), i == size - 1);
  endtask

  task automatic random_config();
    int head;
    int tracks;
    case ($urandom_range(0, 3))
      0: head = 0;
      1: head = 65535;
      default: head = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 6))
      0: tracks = 0;
      1: tracks = 1;
      2: tracks = 65536;
      3: tracks = 131071;
      4: tracks = $urandom_range(2, 256);
      5: tracks = head + 1;
      default: tracks = $urandom_range(1, 65536);
    endcase
    set_config(head, tracks, $urandom_range(0, 1));
  endtask

  initial begin
    int batch_no;
    int size;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: head at 0, sweeping up, top reached by a request
    send_request(16'hFFFF, 1'b0);
    send_request(16'h0000, 1'b1);
    drain();
    // zero tracks, sweeping down from the top
    set_config(65535, 0, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'h8000, 1'b1);
    drain();
    // one track: requests above the top, edge move is downward
    set_config(100, 1, 1'b1);
    send_request(16'd200, 1'b0);
    send_request(16'd50, 1'b0);
    send_request(16'd100, 1'b1);
    drain();
    // track count past the largest track number, only higher requests
    set_config(16'h5555, 131071, 1'b0);
    send_request(16'hAAAA, 1'b1);
    drain();
    // head already at the top
    set_config(65535, 65536, 1'b1);
    send_request(16'hFFFF, 1'b1);
    drain();

    batch_no = 0;
    while (items_sent < 230) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if (batch_no == 2)
        size = MAX_BATCH;
      else if (batch_no == 4 || $urandom_range(0, 9) == 0)
        size = $urandom_range(MAX_BATCH + 1, MAX_BATCH + 4);
      else
        size = $urandom_range(1, 10);
      run_batch(size);
      if ($urandom_range(0, 2) == 0) begin
        drain();
        random_config();
      end
      batch_no++;
    end

    drain();
    if (sb.errors == 0)
      $display("scan_disk_scheduler test passed");
    else
      $display("scan_disk_scheduler test failed");
    $finish;
  end
endmodule
